[src/tcw_pkg.sv]
package tcw_pkg;

    // Field widths on the stream ports
    localparam int CODE_W    = 8;
    localparam int COLOR_W   = 8;
    localparam int IN_ROW_W  = 5;
    localparam int IN_COL_W  = 7;
    localparam int CUR_ROW_W = 5;
    localparam int CUR_COL_W = 7;

    // Packed bus widths, rounded up to whole bytes
    localparam int S_DATA_W = 24;   // 8 + 5 + 7 = 20 -> 24
    localparam int M_DATA_W = 32;   // 8 + 8 + 5 + 7 + 1 = 29 -> 32

    // Opcodes carried in s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // Character codes
    localparam logic [CODE_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CODE_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'h07;

    // One character cell: attribute in the high byte, character in the low byte
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [CODE_W-1:0]  code;
    } cell_t;

    localparam cell_t RESET_CELL = '{color: RESET_COLOR, code: SPACE_CODE};

endpackage

[src/text_console_writer.sv]
// Text console writer: keeps a ROWS x COLUMNS frame of character cells
// (attribute byte over character byte) in one block RAM plus a cursor.
// An input transaction with s_tuser = 0 writes char_code at the cursor and
// advances it (code 10 is a newline and stores nothing); s_tuser = 1 reads
// the cell at read_row/read_column (zero if outside the frame). Every
// transaction gives exactly one result with the cursor after it and a
// scrolled flag. A character write or newline loads its result directly,
// a read through the registered RAM read and the ST_READ state. A write
// that moves past the bottom row scrolls: the RAM is walked once, copying
// (ROWS-1)*COLUMNS cells at one per cycle through its single write port
// and then blanking COLUMNS cells in the current text_color. After reset
// the block clears the RAM to spaces in color 7, one cell per cycle,
// before the first input transaction is taken; text_color writes are
// accepted at any time on the cfg port.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config: text_color
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcw_pkg::COLOR_W-1:0]    cfg_data,
    // input: char_code [7:0], read_row [12:8], read_column [19:13]
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tcw_pkg::S_DATA_W-1:0]   s_tdata,
    // input: opcode [0]
    input  logic [0:0]                     s_tuser,
    // output: cell_char [7:0], cell_color [15:8], cursor_row [20:16],
    //         cursor_column [27:21], scrolled [28]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcw_pkg::M_DATA_W-1:0]   m_tdata
);

    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_COPY  = 3'd3;
    localparam logic [2:0] ST_BLANK = 3'd4;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_COPY = AW'(CELLS - COLUMNS - 1);
    localparam logic [AW-1:0] FIRST_BOT = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] ROW_STEP  = AW'(COLUMNS);
    localparam logic [RW-1:0] LAST_ROW  = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL  = CW'(COLUMNS - 1);

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [RW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [COLOR_W-1:0]  color_reg, color_next;
    logic                copy_pend_reg, copy_pend_next;
    logic [AW-1:0]       copy_addr_reg, copy_addr_next;
    logic                rd_ok_reg, rd_ok_next;
    logic                m_valid_reg, m_valid_next;
    logic [CODE_W-1:0]   out_char_reg, out_char_next;
    logic [COLOR_W-1:0]  out_color_reg, out_color_next;
    logic                out_scroll_reg, out_scroll_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    cell_t               wr_data;
    logic [AW-1:0]       rd_addr;
    cell_t               rd_data;

    logic                accept;
    logic                in_op;
    logic [CODE_W-1:0]   in_code;
    logic [IN_ROW_W-1:0] in_row;
    logic [IN_COL_W-1:0] in_col;
    logic                wrap;
    logic [AW-1:0]       cursor_addr;

    // Input fields
    assign in_op   = s_tuser[0];
    assign in_code = s_tdata[7:0];
    assign in_row  = s_tdata[12:8];
    assign in_col  = s_tdata[19:13];

    assign accept      = s_tvalid && s_tready;
    assign s_tready    = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign cfg_ready   = 1'b1;
    assign cursor_addr = AW'(32'(row_reg) * COLUMNS) + AW'(col_reg);
    assign wrap        = (in_code == NEWLINE_CODE) || (col_reg == LAST_COL);

    // Frame store
    tcw_ram #(
        .WIDTH ($bits(cell_t)),
        .DEPTH (CELLS)
    ) u_frame (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Control, write-port mux and result loading
    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        color_next      = color_reg;
        copy_pend_next  = 1'b0;
        copy_addr_next  = copy_addr_reg;
        rd_ok_next      = rd_ok_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        out_char_next   = out_char_reg;
        out_color_next  = out_color_reg;
        out_scroll_next = out_scroll_reg;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = RESET_CELL;
        rd_addr         = AW'(32'(in_row) * COLUMNS + 32'(in_col));

        if (cfg_valid) begin
            color_next = cfg_data;
        end

        // A copied cell is written in the cycle after its read
        if (copy_pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rd_data;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
                if (idx_reg == LAST_CELL) begin
                    idx_next   = '0;
                    state_next = ST_IDLE;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_op == OP_READ) begin
                        rd_ok_next = (32'(in_row) < ROWS) && (32'(in_col) < COLUMNS);
                        state_next = ST_READ;
                    end else begin
                        if (in_code != NEWLINE_CODE) begin
                            wr_en   = 1'b1;
                            wr_addr = cursor_addr;
                            wr_data = '{color: color_reg, code: in_code};
                        end
                        col_next = wrap ? '0 : col_reg + CW'(1);
                        if (wrap && row_reg == LAST_ROW) begin
                            // scroll: cursor stays on bottom row
                            idx_next   = '0;
                            state_next = ST_COPY;
                        end else begin
                            if (wrap) begin
                                row_next = row_reg + RW'(1);
                            end
                            m_valid_next    = 1'b1;
                            out_char_next   = '0;
                            out_color_next  = '0;
                            out_scroll_next = 1'b0;
                        end
                    end
                end
            end
            ST_READ: begin
                m_valid_next    = 1'b1;
                out_char_next   = rd_ok_reg ? rd_data.code : '0;
                out_color_next  = rd_ok_reg ? rd_data.color : '0;
                out_scroll_next = 1'b0;
                state_next      = ST_IDLE;
            end
            ST_COPY: begin
                rd_addr        = idx_reg + ROW_STEP;
                copy_pend_next = 1'b1;
                copy_addr_next = idx_reg;
                if (idx_reg == LAST_COPY) begin
                    idx_next   = FIRST_BOT;
                    state_next = ST_BLANK;
                end else begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            ST_BLANK: begin
                // wait out the last copy write before blanking
                if (!copy_pend_reg) begin
                    wr_en   = 1'b1;
                    wr_data = '{color: color_reg, code: SPACE_CODE};
                    if (idx_reg == LAST_CELL) begin
                        idx_next        = '0;
                        state_next      = ST_IDLE;
                        m_valid_next    = 1'b1;
                        out_char_next   = '0;
                        out_color_next  = '0;
                        out_scroll_next = 1'b1;
                    end else begin
                        idx_next = idx_reg + AW'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            color_reg     <= RESET_COLOR;
            copy_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            color_reg     <= color_next;
            copy_pend_reg <= copy_pend_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        copy_addr_reg  <= copy_addr_next;
        rd_ok_reg      <= rd_ok_next;
        out_char_reg   <= out_char_next;
        out_color_reg  <= out_color_next;
        out_scroll_reg <= out_scroll_next;
    end

    // Result; cursor only moves when a new transaction is taken
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, out_scroll_reg, CUR_COL_W'(col_reg), CUR_ROW_W'(row_reg),
                       out_color_reg, out_char_reg};

endmodule

[src/tcw_ram.sv]
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
